// ===== sv/lsb_first_bit_field_reader_unit_assert.svh =====
// Assertion macros shared by the bit-field reader checker.
`ifndef LSB_FIRST_BIT_FIELD_READER_UNIT_ASSERT_SVH
`define LSB_FIRST_BIT_FIELD_READER_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define LBFR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define LBFR_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lbfr_pkg.sv =====
// Shared constants, types and helpers of the bit-field reader.
package lbfr_pkg;

  localparam int BUFFER_BYTES_DEF  = 1024;
  localparam int MAX_READ_BITS_DEF = 64;

  localparam int OPCODE_W = 2;
  localparam int ADDR_W   = 10;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int VALUE_W  = 64;
  localparam int CURSOR_W = 14;

  localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

  localparam logic [CURSOR_W-1:0] STREAM_BITS_RST = 14'd8192;

  // control from the sequencer to the byte gather shift register
  typedef struct packed {
    logic shift;
    logic load_byte;
  } gather_ctrl_t;

  // bytes a read of max_bits bits can touch at any bit offset
  function automatic int gather_bytes(input int max_bits);
    return (max_bits + 2 * BYTE_W - 2) / BYTE_W;
  endfunction

endpackage

// ===== sv/lbfr_if.sv =====
// Channel interfaces: request, response and configuration write.
interface lbfr_req_if;
  import lbfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ADDR_W-1:0]   byte_address;
  logic [BYTE_W-1:0]   byte_value;
  logic [COUNT_W-1:0]  bit_count;

  modport source (output valid, opcode, byte_address, byte_value, bit_count, input ready);
  modport sink (input valid, opcode, byte_address, byte_value, bit_count, output ready);
endinterface

interface lbfr_rsp_if;
  import lbfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  read_value;
  logic                overrun;
  logic [CURSOR_W-1:0] cursor_after;

  modport source (output valid, read_value, overrun, cursor_after, input ready);
  modport sink (input valid, read_value, overrun, cursor_after, output ready);
endinterface

interface lbfr_cfg_if;
  import lbfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] stream_bits;

  modport source (output valid, stream_bits, input ready);
  modport sink (input valid, stream_bits, output ready);
endinterface

// ===== sv/lbfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lbfr_gather.sv =====
// Byte-serial gather register: collects fetched bytes, then aligns and masks the field.
module lbfr_gather #(
  parameter int MAX_READ_BITS = lbfr_pkg::MAX_READ_BITS_DEF
) (
  input  logic                        clk,
  input  lbfr_pkg::gather_ctrl_t      ctrl,
  input  logic [lbfr_pkg::BYTE_W-1:0] rd_byte,
  input  logic [2:0]                  bit_offset,
  input  logic [lbfr_pkg::COUNT_W-1:0] bit_count,
  output logic [MAX_READ_BITS-1:0]    value
);
  import lbfr_pkg::*;

  localparam int NBYTES = gather_bytes(MAX_READ_BITS);
  localparam int ACC_W  = NBYTES * BYTE_W;

  logic [ACC_W-1:0]         acc;
  logic [BYTE_W-1:0]        shift_in;
  logic [ACC_W-1:0]         aligned;
  logic [MAX_READ_BITS-1:0] mask;

  // bytes enter at the top; after NBYTES shifts byte j sits at bit 8*j
  assign shift_in = ctrl.load_byte ? rd_byte : '0;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      acc <= {shift_in, acc[ACC_W-1:BYTE_W]};
    end
  end

  assign aligned = acc >> bit_offset;

  always_comb begin
    for (int i = 0; i < MAX_READ_BITS; i++) begin
      mask[i] = COUNT_W'(i) < bit_count;
    end
  end

  assign value = aligned[MAX_READ_BITS-1:0] & mask;

endmodule

// ===== sv/lsb_first_bit_field_reader_unit.sv =====
// Top level of the LSB-first bit-field reader.
//
//   channel  role    transfers
//   req      sink    opcode, byte_address, byte_value, bit_count
//   rsp      source  read_value, overrun, cursor_after (one per request)
//   cfg      sink    stream_bits, always ready
//
// A read that is not refused fetches its bytes one buffer byte per cycle through the
// single read port, whose read data is registered, into the gather register, then passes
// through the finish state back to idle; other requests go from idle straight to finish.
// Reset clears the cursor and sets stream_bits to 8192; buffer bytes stay unknown.
// A stalled response holds its register; the next request is still taken, and
// its result waits in the finish state until the response register frees.
module lsb_first_bit_field_reader_unit #(
  parameter int BUFFER_BYTES  = lbfr_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_READ_BITS = lbfr_pkg::MAX_READ_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  lbfr_req_if.sink   req,
  lbfr_rsp_if.source rsp,
  lbfr_cfg_if.sink   cfg
);
  import lbfr_pkg::*;

  localparam int AW        = $clog2(BUFFER_BYTES);
  localparam int NBYTES    = gather_bytes(MAX_READ_BITS);
  localparam int STEP_W    = $clog2(NBYTES + 1);
  localparam int PTR_W     = CURSOR_W - 3;
  localparam int LIMIT_CAP = (BUFFER_BYTES * 8 < 2 ** CURSOR_W) ?
                             BUFFER_BYTES * 8 : 2 ** CURSOR_W - 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FETCH  = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]          state;
  logic [CURSOR_W-1:0] stream_bits;
  logic [CURSOR_W-1:0] cursor;
  logic [CURSOR_W-1:0] cursor_next;
  logic [OPCODE_W-1:0] item_op;
  logic [COUNT_W-1:0]  item_count;
  logic                item_over;
  logic [2:0]          item_off;
  logic [PTR_W-1:0]    item_ptr;
  logic [STEP_W-1:0]   item_nbytes;
  logic [STEP_W-1:0]   step;
  logic                rd_pend;

  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic                out_over;
  logic [CURSOR_W-1:0] out_cursor;

  logic                accept;
  logic [CURSOR_W-1:0] limit;
  logic [CURSOR_W:0]   reach;
  logic                over_now;
  logic [COUNT_W:0]    span;
  logic                in_range;
  logic                out_free;
  logic                is_read_ok;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;
  gather_ctrl_t        gctrl;
  logic [MAX_READ_BITS-1:0] gath_value;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid & req.ready;
  assign cfg.ready = 1'b1;

  assign limit    = (stream_bits < CURSOR_W'(LIMIT_CAP)) ? stream_bits : CURSOR_W'(LIMIT_CAP);
  assign reach    = {1'b0, cursor} + (CURSOR_W + 1)'(req.bit_count);
  assign over_now = (req.bit_count > COUNT_W'(MAX_READ_BITS)) || (reach > {1'b0, limit});
  // bytes spanned by the field: ceil((offset + count) / 8)
  assign span     = {5'd0, cursor[2:0]} + {1'b0, req.bit_count} + (COUNT_W + 1)'(7);
  assign in_range = int'(req.byte_address) < BUFFER_BYTES;

  assign ram_we    = accept && (req.opcode == OP_WRITE) && in_range;
  assign ram_re    = (state == S_FETCH) && (step < item_nbytes);
  assign ram_raddr = AW'(item_ptr + PTR_W'(step));

  assign gctrl.shift     = (state == S_FETCH) && (step != '0);
  assign gctrl.load_byte = rd_pend;

  assign out_free   = !out_valid || rsp.ready;
  assign is_read_ok = (item_op == OP_READ) && !item_over;

  always_comb begin
    cursor_next = cursor;
    if (is_read_ok) begin
      cursor_next = cursor + CURSOR_W'(item_count);
    end else if (item_op == OP_RESTART) begin
      cursor_next = '0;
    end
  end

  lbfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_buffer (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(req.byte_address)),
    .wdata (req.byte_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lbfr_gather #(
    .MAX_READ_BITS (MAX_READ_BITS)
  ) u_gather (
    .clk        (clk),
    .ctrl       (gctrl),
    .rd_byte    (ram_rdata),
    .bit_offset (item_off),
    .bit_count  (item_count),
    .value      (gath_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stream_bits <= STREAM_BITS_RST;
      cursor      <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      step        <= '0;
    end else begin
      rd_pend <= ram_re;
      if (cfg.valid) begin
        stream_bits <= cfg.stream_bits;
      end
      // a new result may replace one leaving in the same cycle
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            step <= '0;
            if ((req.opcode == OP_READ) && !over_now) begin
              state <= S_FETCH;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FETCH: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(NBYTES)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            cursor    <= cursor_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item and response payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op     <= req.opcode;
      item_count  <= req.bit_count;
      item_over   <= over_now;
      item_off    <= cursor[2:0];
      item_ptr    <= cursor[CURSOR_W-1:3];
      item_nbytes <= STEP_W'(span >> 3);
    end
    if ((state == S_FINISH) && out_free) begin
      out_value  <= is_read_ok ? VALUE_W'(gath_value) : '0;
      out_over   <= (item_op == OP_READ) && item_over;
      out_cursor <= cursor_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_value   = out_value;
  assign rsp.overrun      = out_over;
  assign rsp.cursor_after = out_cursor;

endmodule

// ===== sv/lbfr_checker.sv =====
// Port-level checker of the bit-field reader and its bind to the top level.
module lbfr_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_read_value,
  input logic        rsp_overrun,
  input logic [13:0] rsp_cursor_after
);

`include "lsb_first_bit_field_reader_unit_assert.svh"

  logic [78:0] rsp_payload;

  assign rsp_payload = {rsp_read_value, rsp_overrun, rsp_cursor_after};

  `LBFR_ASSERT_RST(a_rst_clears_rsp, clk, rst |=> !rsp_valid, "response valid after reset")

  `LBFR_ASSERT(a_overrun_zero, clk, rst, rsp_valid && rsp_overrun |-> rsp_read_value == 64'd0, "refused read carries data")

  `LBFR_ASSERT(a_one_item, clk, rst, req_valid && req_ready |=> !req_ready, "request taken while item in flight")

  `LBFR_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled response changed")

endmodule

bind lsb_first_bit_field_reader_unit lbfr_port_checker u_lbfr_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_read_value   (rsp.read_value),
  .rsp_overrun      (rsp.overrun),
  .rsp_cursor_after (rsp.cursor_after)
);

// ===== dv/lbfr_checker.sv =====
// Scoreboard of the bit-field reader: mirrors requests, predicts and compares responses.
module lbfr_checker (
  input  logic        clk,
  input  logic        rst,
  lbfr_req_if         req,
  lbfr_rsp_if         rsp,
  lbfr_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lbfr_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic                overrun;
    logic [CURSOR_W-1:0] cursor_after;
  } read_result_t;

  logic [BYTE_W-1:0] byte_image [BUFFER_BYTES_DEF];
  int unsigned       bit_pos;
  int unsigned       length_cap;
  read_result_t      expected_q [$];

  function automatic read_result_t predict_request(input logic [OPCODE_W-1:0] op,
                                                   input logic [ADDR_W-1:0]   addr,
                                                   input logic [BYTE_W-1:0]   data,
                                                   input logic [COUNT_W-1:0]  cnt);
    read_result_t r;
    int unsigned  lim;
    int unsigned  pos;
    int           i;
    r = '0;
    // stream length cannot go past the buffer
    lim = (length_cap < BUFFER_BYTES_DEF * 8) ? length_cap : BUFFER_BYTES_DEF * 8;
    case (op)
      OP_WRITE: begin
        if (addr < BUFFER_BYTES_DEF) byte_image[addr] = data;
      end
      OP_READ: begin
        if (cnt > MAX_READ_BITS_DEF || bit_pos + cnt > lim) begin
          r.overrun = 1'b1;
        end else begin
          for (i = 0; i < cnt; i++) begin
            pos = bit_pos + i;
            r.read_value[i] = byte_image[pos / 8][pos % 8];
          end
          bit_pos += cnt;
        end
      end
      OP_RESTART: begin
        bit_pos = 0;
      end
      default: ;
    endcase
    r.cursor_after = bit_pos[CURSOR_W-1:0];
    return r;
  endfunction

  task automatic note_failure(input string what, input read_result_t want,
                              input read_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s: expected value=%h overrun=%b cursor=%0d, got value=%h overrun=%b cursor=%0d",
               $realtime, what, want.read_value, want.overrun, want.cursor_after,
               got.read_value, got.overrun, got.cursor_after);
  endtask

  always @(posedge clk) begin
    read_result_t got;
    read_result_t want;
    if (rst) begin
      expected_q.delete();
      bit_pos = 0;
      length_cap = STREAM_BITS_RST;
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.read_value, rsp.overrun, rsp.cursor_after};
        if (expected_q.size() == 0) begin
          note_failure("response with no request waiting", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.read_value !== want.read_value || got.overrun !== want.overrun ||
              got.cursor_after !== want.cursor_after)
            note_failure("response mismatch", want, got);
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(predict_request(req.opcode, req.byte_address, req.byte_value,
                                             req.bit_count));
      if (cfg.valid && cfg.ready) length_cap = cfg.stream_bits;
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== dv/tb_lsb_first_bit_field_reader_unit.sv =====
// Testbench top of the bit-field reader: clock, reset, stimulus, back-pressure and verdict.
module tb_lsb_first_bit_field_reader_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lbfr_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;

  lbfr_req_if req_ch ();
  lbfr_rsp_if rsp_ch ();
  lbfr_cfg_if cfg_ch ();

  lsb_first_bit_field_reader_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  lbfr_checker chk (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  // stimulus-side view: which bytes hold data and where the cursor stands
  bit written [BUFFER_BYTES_DEF];
  int sim_cursor;
  int sim_limit;
  int max_cursor;
  bit quiet;
  int items_sent;
  int n_write, n_read, n_refused, n_restart, n_unused, n_settings;

  function automatic int eff_limit();
    return (sim_limit < BUFFER_BYTES_DEF * 8) ? sim_limit : BUFFER_BYTES_DEF * 8;
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic [COUNT_W-1:0] cnt);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.byte_address <= addr;
    req_ch.byte_value   <= data;
    req_ch.bit_count    <= cnt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    case (op)
      OP_WRITE: begin
        written[addr] = 1'b1;
        n_write++;
      end
      OP_READ: begin
        n_read++;
        if (cnt > MAX_READ_BITS_DEF || sim_cursor + cnt > eff_limit()) n_refused++;
        else sim_cursor += cnt;
        if (sim_cursor > max_cursor) max_cursor = sim_cursor;
      end
      OP_RESTART: begin
        sim_cursor = 0;
        n_restart++;
      end
      default: n_unused++;
    endcase
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_stream_bits(input logic [CURSOR_W-1:0] v);
    wait_all_results();
    // let the block settle into idle after its last transfer
    repeat (4) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.stream_bits <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sim_limit = v;
    n_settings++;
  endtask

  task automatic read_bits(input int cnt);
    send_item(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), COUNT_W'(cnt));
  endtask

  task automatic random_item();
    int r;
    int cnt;
    int b;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    if (r < 28) begin
      if ($urandom_range(0, 1))
        addr = ADDR_W'((sim_cursor / 8 + $urandom_range(0, 15)) % BUFFER_BYTES_DEF);
      else
        addr = ADDR_W'($urandom_range(0, BUFFER_BYTES_DEF - 1));
      send_item(OP_WRITE, addr, BYTE_W'($urandom), COUNT_W'($urandom));
    end else if (r < 91) begin
      case ($urandom_range(0, 9))
        0:       cnt = MAX_READ_BITS_DEF;
        1:       cnt = $urandom_range(MAX_READ_BITS_DEF + 1, 127);
        2:       cnt = $urandom_range(0, 8);
        default: cnt = $urandom_range(0, MAX_READ_BITS_DEF);
      endcase
      // a read that will succeed only touches bytes that already hold data
      if (cnt > 0 && cnt <= MAX_READ_BITS_DEF && sim_cursor + cnt <= eff_limit())
        for (b = sim_cursor / 8; b <= (sim_cursor + cnt - 1) / 8; b++)
          if (!written[b])
            send_item(OP_WRITE, ADDR_W'(b), BYTE_W'($urandom), COUNT_W'($urandom));
      read_bits(cnt);
    end else if (r < 95) begin
      send_item(OP_RESTART, ADDR_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom));
    end else begin
      send_item(OP_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom));
    end
  endtask

  // response side: random stalls, one long hold-off so the block backs up
  initial begin : rsp_drain
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CURSOR_W-1:0] settings [6];
    logic [BYTE_W-1:0]   seed_bytes [9];
    int p;
    int k;
    int start;
    bit paused;
    settings   = '{14'd8192, 14'd0, 14'd16383, 14'd300, 14'd0, 14'd8191};
    seed_bytes = '{8'hA5, 8'h3C, 8'h00, 8'hFF, 8'h81, 8'h7E, 8'h5A, 8'hC3, 8'h96};
    settings[4] = CURSOR_W'($urandom_range(1, 2000));
    sim_cursor = 0;
    sim_limit  = STREAM_BITS_RST;
    paused     = 1'b0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_WRITE;
    req_ch.byte_address <= '0;
    req_ch.byte_value   <= '0;
    req_ch.bit_count    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.stream_bits  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill nine bytes, then reads at every width extreme
    for (k = 0; k < 9; k++) send_item(OP_WRITE, ADDR_W'(k), seed_bytes[k], '0);
    read_bits(0);
    read_bits(3);
    read_bits(MAX_READ_BITS_DEF);     // unaligned, spans all nine bytes
    read_bits(MAX_READ_BITS_DEF + 1); // count above maximum
    read_bits(127);
    send_item(OP_UNUSED, '1, '1, '1);
    send_item(OP_RESTART, '1, '1, '1);
    read_bits(MAX_READ_BITS_DEF);
    send_item(OP_WRITE, ADDR_W'(BUFFER_BYTES_DEF - 1), 8'hFF, '1);
    set_stream_bits(14'd70);
    read_bits(7);                     // one past the limit
    read_bits(6);                     // lands exactly on it
    read_bits(0);
    set_stream_bits(14'd10);
    read_bits(0);                     // limit now below the cursor
    send_item(OP_RESTART, '0, '0, '0);
    read_bits(10);
    read_bits(1);

    for (p = 0; p < 6; p++) begin
      set_stream_bits(settings[p]);
      if (p == 5) quiet = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if (p == 2 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_all_results();
        end
        random_item();
      end
    end

    wait_all_results();
    repeat (16) @(posedge clk);
    $display("Sent %0d requests: %0d byte writes, %0d reads (%0d refused), %0d restarts, %0d unused",
             items_sent, n_write, n_read, n_refused, n_restart, n_unused);
    $display("Stream length written %0d times; cursor reached bit %0d", n_settings, max_cursor);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
